>>> rtl/core/sitd_pkg.sv
// ----------------------------------------------------------------------------
// sitd_pkg
// Shared types, constants and the reciprocal table of the integer-to-text
// converter.
// ----------------------------------------------------------------------------
package sitd_pkg;

   localparam int MAX_RADIX   = 16;
   localparam int RADIX_W     = $clog2(MAX_RADIX + 1);
   localparam int SYM_W       = 8;
   localparam int ALPHA_W     = SYM_W * MAX_RADIX;
   localparam int HALF_W      = ALPHA_W / 2;
   localparam int DIGIT_W     = $clog2(MAX_RADIX);
   localparam int VALUE_W     = 32;
   localparam int PROD_W      = 2 * VALUE_W;
   localparam int STACK_DEPTH = VALUE_W;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_IDX_LSB = 3;
   localparam int CSR_IDX_W   = CSR_ADDR_W - CSR_IDX_LSB;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIX    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_LO = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_HI = 2'd2;

   localparam logic [RADIX_W-1:0] RADIX_RESET    = 5'd10;
   localparam logic [HALF_W-1:0]  ALPHA_LO_RESET = 64'h3736_3534_3332_3130;
   localparam logic [HALF_W-1:0]  ALPHA_HI_RESET = 64'h0000_0000_0000_3938;

   localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;

   typedef struct packed {
      logic [RADIX_W-1:0] radix;
      logic [ALPHA_W-1:0] alphabet;
   } sitd_cfg_type;

   typedef struct packed {
      logic               invalid;
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } sitd_job_type;

   // floor(2^32 / n); the product then lands at most one below the quotient
   function automatic logic [VALUE_W-1:0] sitd_recip(input logic [RADIX_W-1:0] n);
      logic [VALUE_W-1:0] r;
      case (n)
         5'd2:    r = 32'h8000_0000;
         5'd3:    r = 32'h5555_5555;
         5'd4:    r = 32'h4000_0000;
         5'd5:    r = 32'h3333_3333;
         5'd6:    r = 32'h2AAA_AAAA;
         5'd7:    r = 32'h2492_4924;
         5'd8:    r = 32'h2000_0000;
         5'd9:    r = 32'h1C71_C71C;
         5'd10:   r = 32'h1999_9999;
         5'd11:   r = 32'h1745_D174;
         5'd12:   r = 32'h1555_5555;
         5'd13:   r = 32'h13B1_3B13;
         5'd14:   r = 32'h1249_2492;
         5'd15:   r = 32'h1111_1111;
         5'd16:   r = 32'h1000_0000;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/sitd_front.sv
// ----------------------------------------------------------------------------
// sitd_front
// Request side: takes a value, splits off sign and magnitude and checks the
// digit alphabet, then hands the request to the job queue.
// ----------------------------------------------------------------------------
module sitd_front (
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [sitd_pkg::VALUE_W-1:0]  req_value,
   input  sitd_pkg::sitd_cfg_type        cfg,
   output logic                          q_push,
   input  logic                          q_full,
   output sitd_pkg::sitd_job_type        job
);
   import sitd_pkg::*;

   logic alpha_ok;

   always_comb begin
      logic [SYM_W-1:0] sym;
      sym      = '0;
      alpha_ok = (cfg.radix >= RADIX_W'(2)) && (cfg.radix <= RADIX_W'(MAX_RADIX));
      for (int i = 0; i < MAX_RADIX; i++) begin
         if (RADIX_W'(i) < cfg.radix) begin
            sym = cfg.alphabet[SYM_W*i +: SYM_W];
            if (sym == CHAR_NUL || sym == CHAR_PLUS || sym == CHAR_MINUS) begin
               alpha_ok = 1'b0;
            end
            // pairwise compare against every later symbol in use
            for (int j = i + 1; j < MAX_RADIX; j++) begin
               if (RADIX_W'(j) < cfg.radix && cfg.alphabet[SYM_W*j +: SYM_W] == sym) begin
                  alpha_ok = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      job.invalid = !alpha_ok;
      job.neg     = req_value[VALUE_W-1];
      job.mag     = req_value[VALUE_W-1] ? (~req_value + VALUE_W'(1)) : req_value;
   end

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

endmodule

>>> rtl/core/sitd_queue.sv
// ----------------------------------------------------------------------------
// sitd_queue
// Short job queue between the request side and the conversion engine.
// ----------------------------------------------------------------------------
module sitd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sitd_pkg::sitd_job_type push_job,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output sitd_pkg::sitd_job_type head_job
);
   import sitd_pkg::*;

   sitd_job_type          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/sitd_back.sv
// ----------------------------------------------------------------------------
// sitd_back
// Conversion engine: peels digits off the magnitude with a reciprocal
// multiply and remainder fix-up, stacks them, then plays the text out most
// significant digit first through the result register.
// ----------------------------------------------------------------------------
module sitd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  sitd_pkg::sitd_cfg_type       cfg,
   input  logic                         q_empty,
   output logic                         q_pop,
   input  sitd_pkg::sitd_job_type       job,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [sitd_pkg::SYM_W-1:0]   rsp_character,
   output logic                         rsp_last,
   output logic                         rsp_alphabet_invalid
);
   import sitd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_FIX  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [VALUE_W-1:0]  mag_ff, mag_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic                inv_ff, inv_in;
   logic                out_valid_ff, out_valid_in;
   logic [SYM_W-1:0]    out_char_ff, out_char_in;
   logic                out_last_ff, out_last_in;
   logic                out_inv_ff, out_inv_in;
   logic [DIGIT_W-1:0]  stack_ff [STACK_DEPTH];

   logic                stack_we;
   logic [VALUE_W-1:0]  quot_est, quot;
   logic [RADIX_W-1:0]  qn_lo, rem_est, rem;
   logic                rem_over;
   logic [STACK_AW-1:0] top_idx;
   logic [DIGIT_W-1:0]  top_digit;
   logic                out_free;

   // estimate is the quotient or one below it, so the remainder fits the
   // low bits and one compare-subtract repairs it
   always_comb begin
      quot_est = prod_ff[PROD_W-1 -: VALUE_W];
      qn_lo    = RADIX_W'(quot_est[RADIX_W-1:0] * cfg.radix);
      rem_est  = mag_ff[RADIX_W-1:0] - qn_lo;
      rem_over = (rem_est >= cfg.radix);
      rem      = rem_over ? rem_est - cfg.radix : rem_est;
      quot     = quot_est + VALUE_W'(rem_over);
   end

   assign top_idx   = STACK_AW'(cnt_ff - CNT_W'(1));
   assign top_digit = stack_ff[top_idx];
   assign out_free  = !out_valid_ff || rsp_pop;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      inv_in       = inv_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_inv_in   = out_inv_ff;
      q_pop        = 1'b0;
      stack_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               mag_in   = job.mag;
               neg_in   = job.neg;
               inv_in   = job.invalid;
               cnt_in   = '0;
               state_in = job.invalid ? ST_EMIT : ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(mag_ff) * PROD_W'(sitd_recip(cfg.radix));
            state_in = ST_FIX;
         end
         ST_FIX: begin
            stack_we = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
            mag_in   = quot;
            state_in = (quot == '0) ? ST_EMIT : ST_MUL;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (inv_ff) begin
                  out_char_in = CHAR_NUL;
                  out_last_in = 1'b1;
                  out_inv_in  = 1'b1;
                  state_in    = ST_IDLE;
               end else if (neg_ff) begin
                  out_char_in = CHAR_MINUS;
                  out_last_in = 1'b0;
                  out_inv_in  = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  out_char_in = cfg.alphabet[SYM_W*top_digit +: SYM_W];
                  out_last_in = (cnt_ff == CNT_W'(1));
                  out_inv_in  = 1'b0;
                  cnt_in      = cnt_ff - CNT_W'(1);
                  if (cnt_ff == CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      inv_ff      <= inv_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_inv_ff  <= out_inv_in;
      if (stack_we) begin
         stack_ff[cnt_ff[STACK_AW-1:0]] <= DIGIT_W'(rem);
      end
   end

   assign rsp_empty            = !out_valid_ff;
   assign rsp_character        = out_char_ff;
   assign rsp_last             = out_last_ff;
   assign rsp_alphabet_invalid = out_inv_ff;

endmodule

>>> rtl/core/signed_integer_to_radix_digits_top.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_top
// Signed 32-bit integer to text in a programmable radix and digit alphabet.
// ----------------------------------------------------------------------------
// Each request is a signed value; the response is its text, one character
// per response, a leading '-' for negative values, last set on the final
// digit. An alphabet that is shorter than two symbols, longer than 16, or
// holds a zero byte, '+', '-' or a repeat gives one response with
// alphabet_invalid set and character zero. Requests enter a two-deep queue;
// the engine takes one at a time. Each digit passes the reciprocal-multiply
// divider in two steps (multiply, then remainder fix-up); the characters
// then leave through the result register, the sign first.
// Registers: radix_length at 0x00, alphabet_lower at 0x08, alphabet_upper
// at 0x10, 64-bit data; write them only while the block is idle.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic signed [31:0]               req_value,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [7:0]                       rsp_character,
   output logic                             rsp_last,
   output logic                             rsp_alphabet_invalid,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sitd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sitd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sitd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import sitd_pkg::*;

   logic [RADIX_W-1:0]   radix_ff;
   logic [HALF_W-1:0]    alpha_lo_ff, alpha_hi_ff;
   logic                 csr_wr;
   logic [CSR_IDX_W-1:0] csr_idx;
   sitd_cfg_type         cfg;

   logic                 q_push, q_full, q_pop, q_empty;
   sitd_job_type         push_job, head_job;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:CSR_IDX_LSB];

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= RADIX_RESET;
         alpha_lo_ff <= ALPHA_LO_RESET;
         alpha_hi_ff <= ALPHA_HI_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_RADIX:    radix_ff    <= csr_pwdata[RADIX_W-1:0];
            CSR_ALPHA_LO: alpha_lo_ff <= csr_pwdata[HALF_W-1:0];
            CSR_ALPHA_HI: alpha_hi_ff <= csr_pwdata[HALF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_RADIX:    csr_prdata = CSR_DATA_W'(radix_ff);
         CSR_ALPHA_LO: csr_prdata = CSR_DATA_W'(alpha_lo_ff);
         CSR_ALPHA_HI: csr_prdata = CSR_DATA_W'(alpha_hi_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.radix    = radix_ff;
   assign cfg.alphabet = {alpha_hi_ff, alpha_lo_ff};

   sitd_front u_front (
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .cfg       (cfg),
      .q_push    (q_push),
      .q_full    (q_full),
      .job       (push_job)
   );

   sitd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   sitd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .q_empty              (q_empty),
      .q_pop                (q_pop),
      .job                  (head_job),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_character        (rsp_character),
      .rsp_last             (rsp_last),
      .rsp_alphabet_invalid (rsp_alphabet_invalid)
   );

   // a flagged response stands alone and carries no character
   a_invalid_alone: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_alphabet_invalid) |-> (rsp_last && rsp_character == CHAR_NUL))
      else $error("invalid-alphabet response is not a lone empty item");

   // a sign is always followed by at least one digit
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_alphabet_invalid && rsp_character == CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign marked as final character");

   // nothing is offered straight after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("response offered right after reset");

endmodule

>>> tb/signed_integer_to_radix_digits_top_tb.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_top_tb
// Self-checking bench for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
// Values go in through the request queue and are spelled out in software for
// the current radix and alphabet, one expected character per response. Every
// popped response is compared with the oldest expected character. Directed
// requests cover the reset alphabet, binary and hex extremes, the most
// negative value and each way an alphabet can be rejected. A stretch with
// the response side held off fills the block. Random phases reprogram the
// alphabet between drains, with random idling on both sides.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import sitd_pkg::*;

   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int HOLD_LEN      = 400;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASES        = 10;
   localparam int PHASE_VALUES  = 38;

   localparam logic [HALF_W-1:0] HEX_LO = 64'h3736_3534_3332_3130;
   localparam logic [HALF_W-1:0] HEX_HI = 64'h6665_6463_6261_3938;

   typedef struct packed {
      logic [SYM_W-1:0] chr;
      logic             last;
      logic             invalid;
   } text_char_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic signed [31:0]     req_value = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [7:0]             rsp_character;
   logic                   rsp_last;
   logic                   rsp_alphabet_invalid;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   sitd_cfg_type  cur_cfg = '{radix: RADIX_RESET, alphabet: {ALPHA_HI_RESET, ALPHA_LO_RESET}};
   text_char_type pending_chars[$];

   bit idle_on   = 1'b1;
   bit long_hold = 1'b0;
   int cycle_count;
   int fail_count;
   int values_sent;
   int chars_checked;
   int settings_used;
   int rejected_values;

   signed_integer_to_radix_digits_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_value            (req_value),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_character        (rsp_character),
      .rsp_last             (rsp_last),
      .rsp_alphabet_invalid (rsp_alphabet_invalid),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles, %0d characters still owed",
                  CYCLE_LIMIT, pending_chars.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic bit alphabet_usable(input sitd_cfg_type c);
      logic [SYM_W-1:0] s;
      if (c.radix < 2 || c.radix > MAX_RADIX)
         return 1'b0;
      for (int i = 0; i < c.radix; i++) begin
         s = c.alphabet[SYM_W*i +: SYM_W];
         if (s == CHAR_NUL || s == CHAR_PLUS || s == CHAR_MINUS)
            return 1'b0;
         for (int j = i + 1; j < c.radix; j++)
            if (c.alphabet[SYM_W*j +: SYM_W] == s)
               return 1'b0;
      end
      return 1'b1;
   endfunction

   // queues the characters the block owes for one accepted value
   function automatic void spell_value(input logic signed [31:0] v);
      logic [31:0]      mag;
      logic [31:0]      base;
      logic [SYM_W-1:0] digits[$];
      text_char_type    item;
      if (!alphabet_usable(cur_cfg)) begin
         item.chr     = CHAR_NUL;
         item.last    = 1'b1;
         item.invalid = 1'b1;
         pending_chars.push_back(item);
         rejected_values++;
         return;
      end
      base = 32'(cur_cfg.radix);
      // the most negative value wraps to its own unsigned magnitude
      mag = v[31] ? (32'd0 - v) : v;
      do begin
         digits.push_front(cur_cfg.alphabet[SYM_W*(mag % base) +: SYM_W]);
         mag = mag / base;
      end while (mag != 0);
      item.invalid = 1'b0;
      if (v[31]) begin
         item.chr  = CHAR_MINUS;
         item.last = 1'b0;
         pending_chars.push_back(item);
      end
      foreach (digits[k]) begin
         item.chr  = digits[k];
         item.last = (k == digits.size() - 1);
         pending_chars.push_back(item);
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         chars_checked++;
         if (pending_chars.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("response %0d with nothing owed: chr %02h last %0b invalid %0b",
                        chars_checked, rsp_character, rsp_last, rsp_alphabet_invalid);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_character !== want.chr || rsp_last !== want.last ||
                rsp_alphabet_invalid !== want.invalid) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"response %0d: expected chr %02h last %0b invalid %0b,",
                            " got chr %02h last %0b invalid %0b"},
                           chars_checked, want.chr, want.last, want.invalid,
                           rsp_character, rsp_last, rsp_alphabet_invalid);
            end
         end
      end
   end

   // response side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      int pop_gap;
      int hold_cycles;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (long_hold) begin
         rsp_pop <= 1'b0;
         hold_cycles++;
         if (hold_cycles >= HOLD_LEN) begin
            hold_cycles = 0;
            long_hold   = 1'b0;
         end
      end else if (pop_gap > 0) begin
         rsp_pop <= 1'b0;
         pop_gap--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_pop <= 1'b0;
         pop_gap = $urandom_range(1, 15) - 1;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, {CSR_IDX_LSB{1'b0}}};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_RADIX:    cur_cfg.radix = data[RADIX_W-1:0];
         CSR_ALPHA_LO: cur_cfg.alphabet[HALF_W-1:0] = data;
         CSR_ALPHA_HI: cur_cfg.alphabet[ALPHA_W-1:HALF_W] = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_alphabet(input int n, input logic [HALF_W-1:0] lo,
                               input logic [HALF_W-1:0] hi);
      // upper data bits are junk, only the low five bits are kept
      write_csr(CSR_RADIX, {$urandom, 27'($urandom), 5'(n)});
      write_csr(CSR_ALPHA_LO, lo);
      write_csr(CSR_ALPHA_HI, hi);
      settings_used++;
   endtask

   // leaves push high so back-to-back requests need no re-assertion
   task automatic send_value(input logic signed [31:0] v);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 15);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push  <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_full) @(posedge clock);
      spell_value(v);
      values_sent++;
   endtask

   task automatic await_quiet();
      req_push <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value(input int n);
      longint unsigned p;
      int              k;
      logic signed [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 7))
         3: begin
            v = $urandom_range(0, 300);
            if ($urandom_range(0, 1)) v = -v;
         end
         4: begin
            case ($urandom_range(0, 4))
               0:       v = 0;
               1:       v = -1;
               2:       v = 32'sh7FFF_FFFF;
               3:       v = 32'sh8000_0000;
               default: v = 1;
            endcase
         end
         5: begin
            // around a power of the radix, where the digit count changes
            if (n >= 2 && n <= MAX_RADIX) begin
               p = 1;
               k = $urandom_range(1, 31);
               while (k > 0 && p * n <= 64'h8000_0000) begin
                  p = p * n;
                  k--;
               end
               v = 32'(p - $urandom_range(0, 1));
               if ($urandom_range(0, 1)) v = -v;
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic program_random_alphabet(input int n, input bit spoil);
      logic [ALPHA_W-1:0] alpha;
      logic [SYM_W-1:0]   s;
      bit                 fresh;
      int                 pos;
      // symbols past the radix stay random, the block must ignore them
      alpha = {$urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < n && i < MAX_RADIX; i++) begin
         do begin
            s = 8'($urandom_range(1, 255));
            fresh = (s != CHAR_PLUS && s != CHAR_MINUS);
            for (int j = 0; j < i; j++)
               if (alpha[SYM_W*j +: SYM_W] == s) fresh = 1'b0;
         end while (!fresh);
         alpha[SYM_W*i +: SYM_W] = s;
      end
      if (spoil && n >= 2 && n <= MAX_RADIX) begin
         pos = $urandom_range(0, n - 1);
         case ($urandom_range(0, 3))
            0: alpha[SYM_W*pos +: SYM_W] = CHAR_PLUS;
            1: alpha[SYM_W*pos +: SYM_W] = CHAR_MINUS;
            2: alpha[SYM_W*pos +: SYM_W] = CHAR_NUL;
            default: alpha[SYM_W*pos +: SYM_W] =
               alpha[SYM_W*((pos + 1 + $urandom_range(0, n - 2)) % n) +: SYM_W];
         endcase
      end
      set_alphabet(n, alpha[HALF_W-1:0], alpha[ALPHA_W-1:HALF_W]);
   endtask

   task automatic test_reset_defaults();
      send_value(0);
      send_value(7);
      send_value(-1);
      send_value(32'sh7FFF_FFFF);
      send_value(32'sh8000_0000);
      send_value(-305);
      await_quiet();
   endtask

   task automatic test_extreme_radices();
      set_alphabet(2, 64'h3130, 64'h0);
      send_value(32'sh8000_0000);
      send_value(32'sh7FFF_FFFF);
      send_value(-1);
      await_quiet();
      set_alphabet(16, HEX_LO, HEX_HI);
      send_value(32'sh89AB_CDEF);
      send_value(0);
      await_quiet();
      // symbols with the top bits set
      set_alphabet(16, 64'hF8F9_FAFB_FCFD_FEFF, 64'hF0F1_F2F3_F4F5_F6F7);
      send_value(-1);
      await_quiet();
   endtask

   task automatic test_bad_alphabets();
      // radix out of range in both directions
      set_alphabet(0, HEX_LO, HEX_HI);
      send_value(5);
      await_quiet();
      set_alphabet(1, HEX_LO, HEX_HI);
      send_value(-5);
      await_quiet();
      set_alphabet(17, HEX_LO, HEX_HI);
      send_value(123);
      await_quiet();
      set_alphabet(31, HEX_LO, HEX_HI);
      send_value(32'sh8000_0000);
      await_quiet();
      // forbidden or repeated symbols inside a full hex alphabet
      set_alphabet(16, {HEX_LO[63:8], CHAR_PLUS}, HEX_HI);
      send_value(42);
      await_quiet();
      set_alphabet(16, HEX_LO, {CHAR_MINUS, HEX_HI[55:0]});
      send_value(42);
      await_quiet();
      set_alphabet(16, HEX_LO, {HEX_HI[63:32], CHAR_NUL, HEX_HI[23:0]});
      send_value(-42);
      await_quiet();
      set_alphabet(16, HEX_LO, {HEX_LO[7:0], HEX_HI[55:0]});
      send_value(0);
      await_quiet();
   endtask

   task automatic test_full_queue();
      set_alphabet(10, ALPHA_LO_RESET, ALPHA_HI_RESET);
      idle_on   = 1'b0;
      long_hold = 1'b1;
      // the request side keeps offering while responses are held back
      repeat (20) send_value(pick_value(10));
      await_quiet();
      idle_on = 1'b1;
   endtask

   task automatic test_random_phases();
      int n;
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 0)
            n = 2;
         else if (ph == 1)
            n = MAX_RADIX;
         else if ($urandom_range(0, 7) == 0)
            n = $urandom_range(0, 31);
         else
            n = $urandom_range(2, MAX_RADIX);
         if (ph == PHASES - 1) idle_on = 1'b0;
         program_random_alphabet(n, ph > 1 && $urandom_range(0, 4) == 0);
         repeat (PHASE_VALUES) send_value(pick_value(n));
         await_quiet();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extreme_radices();
      test_bad_alphabets();
      test_full_queue();
      test_random_phases();
      $display("covered %0d values over %0d alphabet settings, %0d of them rejected,",
               values_sent, settings_used, rejected_values);
      $display("with %0d characters compared and %0d mismatches", chars_checked, fail_count);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
